// ===== hdl/lea_pkg.sv =====
package lea_pkg;

  localparam int unsigned NOW_W      = 48;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SHARE_W    = 9;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned MCAND_W    = 16;
  localparam int unsigned PROD_W     = 32;
  localparam int unsigned ENERGY_W   = 63;
  localparam int unsigned MS_W       = 42;
  localparam int unsigned SEC_W      = 32;
  localparam int unsigned QUOT_W     = 33;
  localparam int unsigned REM_W      = 10;
  localparam int unsigned MS_PER_SEC = 1000;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 63;
  localparam int unsigned IN_W       = 80;
  localparam int unsigned OUT_W      = 192;

  localparam logic [PCT_W-1:0] FULL_PCT  = 7'd100;
  localparam logic [GAP_W-1:0] GAP_RESET = 16'd5000;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t REG_INIT_ENERGY = 1'd0;
  localparam cfg_idx_t REG_MAX_GAP     = 1'd1;

  // load starts a new operand, step advances one bit
  typedef struct packed {
    logic load;
    logic step;
  } lea_ctl_t;

endpackage

// ===== hdl/lea_div_serial.sv =====
module lea_div_serial
  import lea_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lea_ctl_t         ctl_i,
  input  logic [MS_W-1:0]  dividend_i,
  output logic [SEC_W-1:0] quot_o
);

  logic [MS_W-1:0]   dvd_q;
  logic [REM_W-1:0]  rem_q;
  logic [QUOT_W-1:0] quot_q;
  logic [REM_W:0]    rem_sh;
  logic              ge;
  logic [REM_W:0]    rem_nx;

  // restoring divide by one second, one dividend bit per step
  always_comb begin
    rem_sh = {rem_q, dvd_q[MS_W-1]};
    ge     = rem_sh >= (REM_W+1)'(MS_PER_SEC);
    rem_nx = ge ? rem_sh - (REM_W+1)'(MS_PER_SEC) : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (ctl_i.load) begin
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (ctl_i.step) begin
      dvd_q  <= {dvd_q[MS_W-2:0], 1'b0};
      rem_q  <= rem_nx[REM_W-1:0];
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign quot_o = (|quot_q[QUOT_W-1:SEC_W]) ? '1 : quot_q[SEC_W-1:0];

endmodule

// ===== hdl/lea_mul_serial.sv =====
module lea_mul_serial
  import lea_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lea_ctl_t           ctl_i,
  input  logic [MCAND_W-1:0] mcand_i,
  input  logic [GAP_W-1:0]   mplier_i,
  output logic [PROD_W-1:0]  prod_o
);

  logic [PROD_W-1:0] mcand_q;
  logic [GAP_W-1:0]  mplier_q;
  logic [PROD_W-1:0] prod_q;

  // shift-add, one multiplier bit per step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcand_q  <= '0;
      mplier_q <= '0;
      prod_q   <= '0;
    end else if (ctl_i.load) begin
      mcand_q  <= PROD_W'(mcand_i);
      mplier_q <= mplier_i;
      prod_q   <= '0;
    end else if (ctl_i.step) begin
      if (mplier_q[0]) begin
        prod_q <= prod_q + mcand_q;
      end
      mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[GAP_W-1:1]};
    end
  end

  assign prod_o = prod_q;

endmodule

// ===== hdl/led_energy_accumulator.sv =====
// result: a sample runs through S_DIFF, S_GAP, S_TIME, S_RUN, S_ACC and S_OUT, then is registered
// samples are worked one at a time, paced by the 42-step bit-serial divide by 1000
// a new sample is taken while the previous result still waits on the output
// config writes are taken only between samples and hold off the input that cycle
// reset: asynchronous active low; clears totals, counters, reference time,
// max gap back to 5000 ms and initial energy to 0
module led_energy_accumulator
  import lea_pkg::*;
#(
  parameter int unsigned TIME_BITS = 48
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // now_ms[47:0], light_on[48], bright_pct[55:49], red_en[56],
  // red_share_pct[63:57], blue_en[64], blue_share_pct[71:65],
  // far_red_en[72], far_red_share_pct[79:73]
  input  logic [IN_W-1:0]       s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // accepted[0], total_energy[63:1], session_energy[126:64],
  // on_time_sec[158:127], full_bright_sec[190:159], zero pad[191]
  output logic [OUT_W-1:0]      m_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned TW = (TIME_BITS < NOW_W) ? TIME_BITS : NOW_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_GAP,
    S_TIME,
    S_RUN,
    S_ACC,
    S_OUT
  } state_e;

  state_e               state_q;
  logic [TW-1:0]        now_q;
  logic                 on_q;
  logic [PCT_W-1:0]     bright_q;
  logic [SHARE_W-1:0]   share_q;
  logic [MCAND_W-1:0]   mcand_q;
  logic [TW-1:0]        last_q;
  logic                 started_q;
  logic [TW:0]          diff_q;
  logic [GAP_W-1:0]     gap_q;
  logic [GAP_W-1:0]     max_gap_q;
  logic                 credit_q;
  logic                 add_e_q;
  logic                 add_f_q;
  logic [ENERGY_W-1:0]  total_q;
  logic [ENERGY_W-1:0]  session_q;
  logic [MS_W-1:0]      on_ms_q;
  logic [MS_W-1:0]      full_ms_q;
  logic [CNT_W-1:0]     cnt_q;
  logic                 m_tvalid_q;
  logic                 out_acc_q;
  logic [ENERGY_W-1:0]  out_total_q;
  logic [ENERGY_W-1:0]  out_session_q;
  logic [SEC_W-1:0]     out_on_sec_q;
  logic [SEC_W-1:0]     out_full_sec_q;

  logic [SHARE_W-1:0]   share_d;
  logic                 credit;
  logic                 gap_big;
  logic [MS_W:0]        on_sum;
  logic [MS_W:0]        full_sum;
  logic [MS_W-1:0]      on_ms_d;
  logic [MS_W-1:0]      full_ms_d;
  logic [ENERGY_W:0]    total_sum;
  logic [ENERGY_W:0]    session_sum;
  logic [PROD_W-1:0]    prod;
  logic [SEC_W-1:0]     on_sec;
  logic [SEC_W-1:0]     full_sec;
  lea_ctl_t             unit_ctl;

  always_comb begin
    share_d = '0;
    if (s_axis_tdata[56]) share_d = share_d + SHARE_W'(s_axis_tdata[63:57]);
    if (s_axis_tdata[64]) share_d = share_d + SHARE_W'(s_axis_tdata[71:65]);
    if (s_axis_tdata[72]) share_d = share_d + SHARE_W'(s_axis_tdata[79:73]);
  end

  always_comb begin
    credit  = started_q && !diff_q[TW] && (|diff_q[TW-1:0]);
    gap_big = (|diff_q[TW-1:GAP_W]) || (diff_q[GAP_W-1:0] > max_gap_q);

    on_sum    = {1'b0, on_ms_q} + (MS_W+1)'(gap_q);
    full_sum  = {1'b0, full_ms_q} + (MS_W+1)'(gap_q);
    on_ms_d   = on_ms_q;
    full_ms_d = full_ms_q;
    if (add_e_q) on_ms_d = on_sum[MS_W] ? '1 : on_sum[MS_W-1:0];
    if (add_f_q) full_ms_d = full_sum[MS_W] ? '1 : full_sum[MS_W-1:0];

    total_sum   = {1'b0, total_q} + (ENERGY_W+1)'(prod);
    session_sum = {1'b0, session_q} + (ENERGY_W+1)'(prod);

    unit_ctl.load = (state_q == S_TIME);
    unit_ctl.step = (state_q == S_RUN);
  end

  lea_mul_serial u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (unit_ctl),
    .mcand_i  (mcand_q),
    .mplier_i (gap_q),
    .prod_o   (prod)
  );

  lea_div_serial u_div_on (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (unit_ctl),
    .dividend_i (on_ms_d),
    .quot_o     (on_sec)
  );

  lea_div_serial u_div_full (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (unit_ctl),
    .dividend_i (full_ms_d),
    .quot_o     (full_sec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      now_q          <= '0;
      on_q           <= 1'b0;
      bright_q       <= '0;
      share_q        <= '0;
      mcand_q        <= '0;
      last_q         <= '0;
      started_q      <= 1'b0;
      diff_q         <= '0;
      gap_q          <= '0;
      max_gap_q      <= GAP_RESET;
      credit_q       <= 1'b0;
      add_e_q        <= 1'b0;
      add_f_q        <= 1'b0;
      total_q        <= '0;
      session_q      <= '0;
      on_ms_q        <= '0;
      full_ms_q      <= '0;
      cnt_q          <= '0;
      m_tvalid_q     <= 1'b0;
      out_acc_q      <= 1'b0;
      out_total_q    <= '0;
      out_session_q  <= '0;
      out_on_sec_q   <= '0;
      out_full_sec_q <= '0;
    end else begin
      if (m_tvalid_q && m_axis_tready && (state_q != S_OUT)) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            now_q    <= s_axis_tdata[TW-1:0];
            on_q     <= s_axis_tdata[48];
            bright_q <= s_axis_tdata[55:49];
            share_q  <= share_d;
            state_q  <= S_DIFF;
          end
        end
        S_DIFF: begin
          diff_q  <= {1'b0, now_q} - {1'b0, last_q};
          mcand_q <= MCAND_W'(bright_q) * MCAND_W'(share_q);
          state_q <= S_GAP;
        end
        S_GAP: begin
          gap_q    <= gap_big ? max_gap_q : diff_q[GAP_W-1:0];
          credit_q <= credit;
          add_e_q  <= credit && on_q && (bright_q != '0);
          add_f_q  <= credit && on_q && (bright_q == FULL_PCT);
          if (!started_q || credit) begin
            last_q <= now_q;
          end
          started_q <= 1'b1;
          state_q   <= S_TIME;
        end
        S_TIME: begin
          on_ms_q   <= on_ms_d;
          full_ms_q <= full_ms_d;
          cnt_q     <= '0;
          state_q   <= S_RUN;
        end
        S_RUN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_W'(MS_W - 1)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          if (add_e_q) begin
            total_q   <= total_sum[ENERGY_W] ? '1 : total_sum[ENERGY_W-1:0];
            session_q <= session_sum[ENERGY_W] ? '1 : session_sum[ENERGY_W-1:0];
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid_q || m_axis_tready) begin
            m_tvalid_q     <= 1'b1;
            out_acc_q      <= credit_q;
            out_total_q    <= total_q;
            out_session_q  <= session_q;
            out_on_sec_q   <= on_sec;
            out_full_sec_q <= full_sec;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_INIT_ENERGY: total_q   <= cfg_data_i;
          REG_MAX_GAP:     max_gap_q <= cfg_data_i[GAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == S_IDLE);
  assign m_axis_tvalid = m_tvalid_q;
  assign m_axis_tdata  = {1'b0, out_full_sec_q, out_on_sec_q, out_session_q,
                          out_total_q, out_acc_q};

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second sample taken while one is in work");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MS_W))
    else $error("bit step counter past the dividend width");

  a_credit_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid_q && out_acc_q) |-> started_q)
    else $error("sample credited before a reference time");

endmodule
